### rtl/ucp_pkg.sv
// Shared types and constants for the UART command parser.
package ucp_pkg;

    localparam int BYTE_W   = 8;
    localparam int PARAM_W  = 2;
    localparam int MANT_W   = 24;
    localparam int FRAC_W   = 3;
    // mantissa * 10 + digit fits in four extra bits
    localparam int MANT_XW  = MANT_W + 4;

    typedef logic [BYTE_W-1:0]  t_byte;
    typedef logic [PARAM_W-1:0] t_param;
    typedef logic [MANT_W-1:0]  t_mant;
    typedef logic [MANT_XW-1:0] t_mant_wide;
    typedef logic [FRAC_W-1:0]  t_frac;

    // Parser state
    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_READY = 3'd1,
        MODE_GET   = 3'd2,
        MODE_SET   = 3'd3,
        MODE_PARAM = 3'd4,
        MODE_VALUE = 3'd5
    } t_parse_mode;

    // Command kinds
    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_SET = 1'b1;

    // Parameter codes
    localparam t_param PRM_T = 2'd0;
    localparam t_param PRM_C = 2'd1;
    localparam t_param PRM_H = 2'd2;
    localparam t_param PRM_V = 2'd3;
    localparam t_param PRM_P = 2'd0;
    localparam t_param PRM_I = 2'd1;
    localparam t_param PRM_D = 2'd2;

    // ASCII codes the parser reacts to
    localparam t_byte CH_HASH  = 8'h23;
    localparam t_byte CH_SEMI  = 8'h3B;
    localparam t_byte CH_G     = 8'h67;
    localparam t_byte CH_S     = 8'h73;
    localparam t_byte CH_P     = 8'h70;
    localparam t_byte CH_I     = 8'h69;
    localparam t_byte CH_D     = 8'h64;
    localparam t_byte CH_T     = 8'h74;
    localparam t_byte CH_C     = 8'h63;
    localparam t_byte CH_H     = 8'h68;
    localparam t_byte CH_V     = 8'h76;
    localparam t_byte CH_COMMA = 8'h2C;
    localparam t_byte CH_POINT = 8'h2E;
    localparam t_byte CH_ZERO  = 8'h30;
    localparam t_byte CH_NINE  = 8'h39;

    // Largest mantissa and fraction count that fit the result fields
    localparam t_mant_wide MANT_MAX = t_mant_wide'({MANT_W{1'b1}});
    localparam t_frac      FRAC_MAX = '1;

    // One parsed command
    typedef struct packed {
        logic   cmd_kind;
        t_param param_code;
        t_mant  value_mantissa;
        t_frac  frac_digits;
    } t_cmd;

endpackage

### rtl/ucp_byte_if.sv
// Received-byte channel: valid/ready handshake with one byte of payload.
interface ucp_byte_if;
    logic                 valid;
    logic                 ready;
    ucp_pkg::t_byte       byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

### rtl/ucp_cmd_if.sv
// Parsed-command channel: valid/ready handshake with the command fields.
interface ucp_cmd_if;
    logic                 valid;
    logic                 ready;
    logic                 cmd_kind;
    ucp_pkg::t_param      param_code;
    ucp_pkg::t_mant       value_mantissa;
    ucp_pkg::t_frac       frac_digits;

    modport source (output valid, output cmd_kind, output param_code,
                    output value_mantissa, output frac_digits, input ready);
    modport sink   (input valid, input cmd_kind, input param_code,
                    input value_mantissa, input frac_digits, output ready);
endinterface

### rtl/uart_command_parser_unit.sv
// UART command parser: byte-serial '#g?;' / '#s?<value>;' decoder.
//
//  channel  | dir | payload                                             | request
//  ---------+-----+-----------------------------------------------------+------------------
//  i_byte   | in  | byte_in[7:0]                                        | one received byte
//  o_cmd    | out | cmd_kind, param_code[1:0], value_mantissa[23:0],    | one parsed command
//           |     | frac_digits[2:0]                                    |
//
//  One byte per clock while i_byte.ready is high. The parser state updates at the edge
//  that takes the byte; a command closed by ';' is registered before it appears on o_cmd.
//  A two-entry output buffer (result register plus skid register) decouples the sides:
//  i_byte.ready drops only while both entries are full.
//  Reset (i_rst_n low, synchronous) returns the parser to idle and empties the buffer.
module uart_command_parser_unit #(
    parameter int MAX_CHARS = 7
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ucp_byte_if.sink   i_byte,
    ucp_cmd_if.source  o_cmd
);
    import ucp_pkg::*;

    localparam int CW = $clog2(MAX_CHARS + 1);

    // Parser state
    t_parse_mode r_mode,         n_mode;
    t_param      r_param,        n_param;
    logic [CW-1:0] r_char_count, n_char_count;
    t_mant       r_mant,         n_mant;
    t_frac       r_frac,         n_frac;
    logic        r_point_seen,   n_point_seen;
    logic        r_num_ended,    n_num_ended;

    // Output buffer
    logic        r_out_valid,    n_out_valid;
    t_cmd        r_out,          n_out;
    logic        r_skid_valid,   n_skid_valid;
    t_cmd        r_skid,         n_skid;

    logic        in_fire;
    logic        emit;
    t_cmd        res;
    t_byte       b;
    logic        is_digit;
    logic        is_point;
    t_mant_wide  mant_next;

    assign b        = i_byte.byte_in;
    assign in_fire  = i_byte.valid && i_byte.ready;
    assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    assign is_point = (b == CH_POINT) || (b == CH_COMMA);
    // acc * 10 + digit; low nibble of an ASCII digit is its value
    assign mant_next = (t_mant_wide'(r_mant) << 3) + (t_mant_wide'(r_mant) << 1)
                     + t_mant_wide'(b[3:0]);

    // Next parser state and result for the byte on the input
    always_comb begin
        n_mode       = r_mode;
        n_param      = r_param;
        n_char_count = r_char_count;
        n_mant       = r_mant;
        n_frac       = r_frac;
        n_point_seen = r_point_seen;
        n_num_ended  = r_num_ended;
        emit         = 1'b0;
        res.cmd_kind       = KIND_GET;
        res.param_code     = r_param;
        res.value_mantissa = '0;
        res.frac_digits    = '0;

        if (b == CH_HASH) begin
            n_mode = MODE_READY;
        end else begin
            unique case (r_mode)
                MODE_READY: begin
                    if (b == CH_G)      n_mode = MODE_GET;
                    else if (b == CH_S) n_mode = MODE_SET;
                    else                n_mode = MODE_IDLE;
                end
                MODE_GET: begin
                    n_mode = MODE_PARAM;
                    if (b == CH_T)      n_param = PRM_T;
                    else if (b == CH_C) n_param = PRM_C;
                    else if (b == CH_H) n_param = PRM_H;
                    else if (b == CH_V) n_param = PRM_V;
                    else                n_mode  = MODE_IDLE;
                end
                MODE_SET: begin
                    if (b == CH_P || b == CH_I || b == CH_D) begin
                        n_mode       = MODE_VALUE;
                        n_param      = (b == CH_P) ? PRM_P : (b == CH_I) ? PRM_I : PRM_D;
                        n_char_count = '0;
                        n_mant       = '0;
                        n_frac       = '0;
                        n_point_seen = 1'b0;
                        n_num_ended  = 1'b0;
                    end else begin
                        n_mode = MODE_IDLE;
                    end
                end
                MODE_PARAM: begin
                    emit   = (b == CH_SEMI);
                    n_mode = MODE_IDLE;
                end
                MODE_VALUE: begin
                    if (is_digit || is_point) begin
                        // only the first MAX_CHARS characters count
                        if (r_char_count < CW'(MAX_CHARS)) begin
                            n_char_count = r_char_count + 1'b1;
                            if (!r_num_ended) begin
                                if (is_point) begin
                                    if (r_point_seen) n_num_ended  = 1'b1;
                                    else              n_point_seen = 1'b1;
                                end else if (mant_next > MANT_MAX ||
                                             (r_point_seen && r_frac == FRAC_MAX)) begin
                                    n_num_ended = 1'b1;
                                end else begin
                                    n_mant = mant_next[MANT_W-1:0];
                                    if (r_point_seen) n_frac = r_frac + 1'b1;
                                end
                            end
                        end
                    end else begin
                        emit               = (b == CH_SEMI);
                        res.cmd_kind       = KIND_SET;
                        res.value_mantissa = r_mant;
                        res.frac_digits    = r_frac;
                        n_mode             = MODE_IDLE;
                    end
                end
                default: n_mode = MODE_IDLE;
            endcase
        end
    end

    // Output buffer: result register in front, skid register behind it
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (r_out_valid && !o_cmd.ready) begin
            if (in_fire && emit) begin
                n_skid_valid = 1'b1;
                n_skid       = res;
            end
        end else if (r_skid_valid) begin
            n_out_valid  = 1'b1;
            n_out        = r_skid;
            n_skid_valid = in_fire && emit;
            n_skid       = res;
        end else begin
            n_out_valid = in_fire && emit;
            n_out       = res;
        end
    end

    // Parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_IDLE;
            r_param      <= '0;
            r_char_count <= '0;
            r_mant       <= '0;
            r_frac       <= '0;
            r_point_seen <= 1'b0;
            r_num_ended  <= 1'b0;
        end else if (in_fire) begin
            r_mode       <= n_mode;
            r_param      <= n_param;
            r_char_count <= n_char_count;
            r_mant       <= n_mant;
            r_frac       <= n_frac;
            r_point_seen <= n_point_seen;
            r_num_ended  <= n_num_ended;
        end
    end

    // Buffer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // Buffer payload
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign i_byte.ready         = !r_skid_valid;
    assign o_cmd.valid          = r_out_valid;
    assign o_cmd.cmd_kind       = r_out.cmd_kind;
    assign o_cmd.param_code     = r_out.param_code;
    assign o_cmd.value_mantissa = r_out.value_mantissa;
    assign o_cmd.frac_digits    = r_out.frac_digits;

endmodule
